/* rtl/core/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Same-cycle implication.
`define BBD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbd assertion failed");
// Next-cycle implication.
`define BBD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbd assertion failed");
`endif

/* rtl/core/bbd_pkg.sv */
`timescale 1ns / 1ps
package bbd_pkg;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BAYER_PAT    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BYPASS       = 2'd3;

  localparam logic [1:0] PAT_RGGB = 2'd0;
  localparam logic [1:0] PAT_GBRG = 2'd3;

  localparam logic [12:0] RESET_WIDTH  = 13'd640;
  localparam logic [15:0] RESET_HEIGHT = 16'd480;

  // floor(x/3) == (x*683)>>11 for every x up to 765.
  localparam logic [9:0] RECIP3 = 10'd683;

  typedef struct packed {
    logic       req_type;
    logic [7:0] raw_pixel;
  } pix_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       end_of_line;
    logic       end_of_frame;
  } pix_out_t;

  typedef struct packed {
    logic sample;    // carries a real sample that updates the line stores
    logic produce;   // an output pixel is formed for this transaction
    logic edge_col;  // the pixel is the last of its line, taken before the shift
    logic lf;
    logic rt;
    logic up;
    logic dn;
    logic ox_odd;
    logic oy_odd;
    logic eol;
    logic eof;
  } cmd_flags_t;

  function automatic logic [7:0] avg_div(input logic [9:0] sum, input logic [2:0] cnt);
    logic [19:0] prod;
    logic [7:0]  res;
    prod = sum * RECIP3;
    case (cnt)
      3'd1:    res = sum[7:0];
      3'd2:    res = sum[8:1];
      3'd3:    res = prod[18:11];
      3'd4:    res = sum[9:2];
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/core/bbd_front.sv */
`timescale 1ns / 1ps
module bbd_front #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  bbd_pkg::pix_in_t     in_data,
  input  logic [12:0]          frame_width,
  input  logic [15:0]          frame_height,
  input  logic                 restart,
  output logic                 push,
  output bbd_pkg::cmd_flags_t  flags,
  output logic [7:0]           pix,
  output logic [$clog2(MAX_WIDTH)-1:0] ix
);
  import bbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int PW = $clog2(MAX_WIDTH + 2);
  localparam int RW = 17;

  logic [CW-1:0] col, col_next, cx;
  logic [RW-1:0] row, row_next, cy, h;
  logic [PW-1:0] pend, pend_next;
  logic [31:0]   fw32, w32;
  logic [WW-1:0] w, w_m1, cxw;
  logic          is_px, renew, first_col, inner, last_px, wrap;

  always_comb begin
    fw32 = 32'(frame_width);
    if (fw32 == 32'd0) begin
      w32 = 32'd1;
    end else if (fw32 > 32'(MAX_WIDTH)) begin
      w32 = 32'(MAX_WIDTH);
    end else begin
      w32 = fw32;
    end
    w    = w32[WW-1:0];
    w_m1 = w - WW'(1);
    h    = (frame_height == 16'd0) ? RW'(1) : RW'(frame_height);

    is_px = (in_data.req_type == REQ_PIXEL);
    renew = (pend != '0) || (row >= h) || (WW'(col) >= w);
    cx    = (is_px && renew) ? '0 : col;
    cy    = (is_px && renew) ? '0 : row;
    cxw   = WW'(cx);

    push = accept && (is_px || (pend != '0));

    first_col = (cx == '0) && (cy >= RW'(2));
    inner     = (cx != '0) && (cy >= RW'(1));

    flags.sample   = is_px;
    flags.produce  = first_col || inner;
    flags.edge_col = first_col;
    flags.lf       = first_col ? (w >= WW'(2)) : (cx >= CW'(2));
    flags.rt       = first_col ? 1'b0 : (cxw < w);
    flags.up       = first_col ? (cy >= RW'(3)) : (cy >= RW'(2));
    flags.dn       = first_col ? ((cy - RW'(1)) < h) : (cy < h);
    flags.ox_odd   = first_col ? w_m1[0] : ~cx[0];
    flags.oy_odd   = first_col ? cy[0] : ~cy[0];
    flags.eol      = first_col;
    flags.eof      = first_col && (cy == h + RW'(1));

    pix = is_px ? in_data.raw_pixel : 8'd0;
    ix  = cx;

    last_px = (cxw == w_m1) && (cy == h - RW'(1));
    wrap    = (cxw + WW'(1)) >= w;

    col_next  = col;
    row_next  = row;
    pend_next = pend;
    if (is_px) begin
      pend_next = '0;
      if (last_px) begin
        col_next  = '0;
        row_next  = h;
        pend_next = PW'(w) + PW'(1);
      end else if (wrap) begin
        col_next = '0;
        row_next = cy + RW'(1);
      end else begin
        col_next = cx + CW'(1);
        row_next = cy;
      end
    end else begin
      pend_next = pend - PW'(1);
      if (pend_next == '0) begin
        col_next = '0;
        row_next = '0;
      end else if (wrap) begin
        col_next = '0;
        row_next = cy + RW'(1);
      end else begin
        col_next = cx + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= '0;
      pend <= '0;
    end else if (push) begin
      col  <= col_next;
      row  <= row_next;
      pend <= pend_next;
    end
  end

endmodule

/* rtl/core/bbd_queue.sv */
`timescale 1ns / 1ps
module bbd_queue #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty,
  output logic             full
);
  localparam int AW = $clog2(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [NW-1:0]    count;

  assign not_empty = (count != '0);
  assign full      = (count == NW'(DEPTH));
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + NW'(1);
      end else if (pop && !push) begin
        count <= count - NW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/core/bbd_back.sv */
`timescale 1ns / 1ps
module bbd_back #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  bbd_pkg::cmd_flags_t  q_flags,
  input  logic [7:0]           q_pix,
  input  logic [$clog2(MAX_WIDTH)-1:0] q_ix,
  output logic                 pop,
  input  logic [1:0]           bayer_pattern,
  input  logic                 bypass,
  output logic                 out_valid,
  input  logic                 out_stall,
  output bbd_pkg::pix_out_t    out_data
);
  import bbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);

  logic          adv;
  // Read stage.
  logic          r_v;
  cmd_flags_t    r_flags;
  logic [7:0]    r_pix;
  logic [CW-1:0] r_ix;
  // Line stores: upper line in the high byte, middle line in the low byte.
  logic [15:0]   lines [MAX_WIDTH];
  logic [15:0]   mem_q, fwd_data, rd;
  logic          fwd_hit;
  // Window stage.
  logic          w_v;
  cmd_flags_t    w_flags;
  logic [7:0]    win [3][3];
  logic [7:0]    nb  [3][3];

  logic [9:0]    hs, vs, ds;
  logic [2:0]    hc, vc, dc;
  logic [7:0]    c, avg_h, avg_v, avg_d, avg_hv, red, green, blue;
  logic          sx, sy;

  assign adv = !out_valid || !out_stall;
  assign pop = q_valid && adv;
  assign rd  = fwd_hit ? fwd_data : mem_q;

  always_ff @(posedge clk) begin
    if (adv) begin
      mem_q    <= lines[q_ix];
      fwd_hit  <= r_v && r_flags.sample && (r_ix == q_ix);
      fwd_data <= {rd[7:0], r_pix};
      if (r_v && r_flags.sample) begin
        lines[r_ix] <= {rd[7:0], r_pix};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_v       <= 1'b0;
      w_v       <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < 3; k++) begin
        for (int j = 0; j < 3; j++) begin
          win[k][j] <= 8'd0;
        end
      end
    end else if (adv) begin
      r_v       <= pop;
      w_v       <= r_v;
      out_valid <= w_v && w_flags.produce;
      if (r_v) begin
        for (int k = 0; k < 3; k++) begin
          win[k][0] <= win[k][1];
          win[k][1] <= win[k][2];
        end
        win[0][2] <= rd[15:8];
        win[1][2] <= rd[7:0];
        win[2][2] <= r_pix;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r_flags <= q_flags;
      r_pix   <= q_pix;
      r_ix    <= q_ix;
      w_flags <= r_flags;
      if (r_v) begin
        // The last pixel of a line is formed from the window before it shifts.
        if (r_flags.edge_col) begin
          for (int k = 0; k < 3; k++) begin
            nb[k][0] <= win[k][1];
            nb[k][1] <= win[k][2];
            nb[k][2] <= 8'd0;
          end
        end else begin
          for (int k = 0; k < 3; k++) begin
            nb[k][0] <= win[k][1];
            nb[k][1] <= win[k][2];
          end
          nb[0][2] <= rd[15:8];
          nb[1][2] <= rd[7:0];
          nb[2][2] <= r_pix;
        end
      end
      out_data.red          <= red;
      out_data.green        <= green;
      out_data.blue         <= blue;
      out_data.end_of_line  <= w_flags.eol;
      out_data.end_of_frame <= w_flags.eof;
    end
  end

  always_comb begin
    hs = (w_flags.lf ? 10'(nb[1][0]) : 10'd0) + (w_flags.rt ? 10'(nb[1][2]) : 10'd0);
    hc = 3'(w_flags.lf) + 3'(w_flags.rt);
    vs = (w_flags.up ? 10'(nb[0][1]) : 10'd0) + (w_flags.dn ? 10'(nb[2][1]) : 10'd0);
    vc = 3'(w_flags.up) + 3'(w_flags.dn);
    ds = ((w_flags.lf && w_flags.up) ? 10'(nb[0][0]) : 10'd0)
       + ((w_flags.lf && w_flags.dn) ? 10'(nb[2][0]) : 10'd0)
       + ((w_flags.rt && w_flags.up) ? 10'(nb[0][2]) : 10'd0)
       + ((w_flags.rt && w_flags.dn) ? 10'(nb[2][2]) : 10'd0);
    dc = 3'(w_flags.lf && w_flags.up) + 3'(w_flags.lf && w_flags.dn)
       + 3'(w_flags.rt && w_flags.up) + 3'(w_flags.rt && w_flags.dn);
    avg_h  = avg_div(hs, hc);
    avg_v  = avg_div(vs, vc);
    avg_d  = avg_div(ds, dc);
    avg_hv = avg_div(hs + vs, hc + vc);
    c  = nb[1][1];
    sx = (bayer_pattern == PAT_RGGB) || (bayer_pattern == PAT_GBRG);
    sy = bayer_pattern[1];
    if (bypass) begin
      red = c; green = c; blue = c;
    end else if (w_flags.oy_odd == sy) begin
      if (w_flags.ox_odd == sx) begin
        red = avg_h; green = c; blue = avg_v;
      end else begin
        red = c; green = avg_hv; blue = avg_d;
      end
    end else begin
      if (w_flags.ox_odd == sx) begin
        red = avg_d; green = avg_hv; blue = c;
      end else begin
        red = avg_v; green = c; blue = avg_h;
      end
    end
  end

endmodule

/* rtl/core/bayer_bilinear_demosaic_unit.sv */
`timescale 1ns / 1ps
// Bilinear Bayer demosaic over a 3x3 neighbourhood.
// Input channel in_valid/in_stall/in_data carries raw 8-bit samples in raster
// order (req_type pixel) or drain ticks (req_type drain). Output channel
// out_valid/out_stall/out_data carries one RGB pixel per raw sample, in raster
// order, with end-of-line and end-of-frame marks.
// The pixel for a sample appears once width+1 further transactions have been
// accepted; the last width+1 pixels of a frame are pushed out by drain ticks.
// Without stalls a transaction passes the command queue, line-store read and
// window stage in turn before it reaches the output register.
// Throughput, when not stalled, is one transaction per cycle, set by the
// line-store memory, which reads one column and writes one column each cycle.
// Configuration is to be written via cfg_wen/cfg_index/cfg_data while idle;
// the block does not enforce it. Writing width or height restarts the frame.
// Reset clears the cursor, the queue and the pipeline and loads 640x480,
// RGGB, bypass off. The line stores need no clearing.
// When the receiver stalls, the back pipeline holds; the four-entry command
// queue keeps taking input until it fills, then in_stall rises.
module bayer_bilinear_demosaic_unit #(
  parameter int MAX_WIDTH = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  bbd_pkg::pix_in_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output bbd_pkg::pix_out_t                   out_data,
  input  logic                                cfg_wen,
  input  logic [bbd_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bbd_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import bbd_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int FW = $bits(cmd_flags_t);
  localparam int QW = CW + 8 + FW;

  logic [12:0] frame_width;
  logic [15:0] frame_height;
  logic [1:0]  bayer_pattern;
  logic        bypass;
  logic        restart, accept, push, pop, q_nonempty, q_full;
  cmd_flags_t  f_flags, q_flags;
  logic [7:0]  f_pix, q_pix;
  logic [CW-1:0] f_ix, q_ix;
  logic [QW-1:0] q_out;

  assign restart  = cfg_wen && ((cfg_index == CFG_FRAME_WIDTH) ||
                                (cfg_index == CFG_FRAME_HEIGHT));
  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RESET_WIDTH;
      frame_height  <= RESET_HEIGHT;
      bayer_pattern <= PAT_RGGB;
      bypass        <= 1'b0;
    end else if (cfg_wen) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width   <= cfg_data[12:0];
        CFG_FRAME_HEIGHT: frame_height  <= cfg_data;
        CFG_BAYER_PAT:    bayer_pattern <= cfg_data[1:0];
        CFG_BYPASS:       bypass        <= cfg_data[0];
        default:          ;
      endcase
    end
  end

  bbd_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .in_data      (in_data),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .restart      (restart),
    .push         (push),
    .flags        (f_flags),
    .pix          (f_pix),
    .ix           (f_ix)
  );

  bbd_queue #(.WIDTH(QW), .DEPTH(4)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data ({f_ix, f_pix, f_flags}),
    .pop       (pop),
    .pop_data  (q_out),
    .not_empty (q_nonempty),
    .full      (q_full)
  );

  assign q_ix    = q_out[QW-1 -: CW];
  assign q_pix   = q_out[FW +: 8];
  assign q_flags = q_out[FW-1:0];

  bbd_back #(.MAX_WIDTH(MAX_WIDTH)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_nonempty),
    .q_flags       (q_flags),
    .q_pix         (q_pix),
    .q_ix          (q_ix),
    .pop           (pop),
    .bayer_pattern (bayer_pattern),
    .bypass        (bypass),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

/* rtl/core/bbd_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bbd_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input bbd_pkg::pix_out_t out_data
);
  import bbd_pkg::*;

  `BBD_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid)
  `BBD_ASSERT_NXT(a_out_stable, clk, rst, out_valid && out_stall, $stable(out_data))
  `BBD_ASSERT_IMP(a_eof_on_eol, clk, rst, out_valid && out_data.end_of_frame, out_data.end_of_line)
  `BBD_ASSERT_NXT(a_reset_quiet, clk, 1'b0, rst, !out_valid)

endmodule

bind bayer_bilinear_demosaic_unit bbd_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
